// ----- rtl/core/polar_gaussian_pair_unit_macros.svh -----
// Assertion macros shared by the polar Gaussian pair RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef POLAR_GAUSSIAN_PAIR_UNIT_MACROS_SVH
`define POLAR_GAUSSIAN_PAIR_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PGP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pgp: assertion failed");

// Next-cycle implication, checked out of reset.
`define PGP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pgp: assertion failed");

`endif

// ----- rtl/core/pgp_pkg.sv -----
// Package for the polar Gaussian pair unit: constants and the sideband struct.
// No dependencies.
package pgp_pkg;

  localparam int unsigned LOG_FRAC_BITS = 24;
  localparam int unsigned DIV_STAGES    = 32;
  localparam int unsigned SQRT_STAGES   = 32;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [30:0] ONE_SQ  = 31'h4000_0000;

  // Per-item values that ride along the pipeline.
  typedef struct packed {
    logic        n0;
    logic        n1;
    logic [16:0] m0;
    logic [16:0] m1;
    logic [30:0] s;
  } pgp_side_t;

endpackage

// ----- rtl/core/pgp_log2.sv -----
// Pipelined -log2(S / 2^30) in Q.24 by normalization and repeated squaring.
// Depends on pgp_pkg.
module pgp_log2 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  pgp_pkg::pgp_side_t side_i,
  output logic               vld_o,
  output logic [28:0]        l_o,
  output pgp_pkg::pgp_side_t side_o
);
  import pgp_pkg::*;

  localparam int unsigned NS = LOG_FRAC_BITS + 1;

  logic              vld_q [NS];
  logic [30:0]       m_q   [NS];
  logic [23:0]       fr_q  [NS];
  logic [4:0]        sh_q  [NS];
  pgp_side_t         sd_q  [NS];
  logic [30:0]       m_nx  [NS];
  logic [23:0]       fr_nx [NS];
  logic              vld_out_q;
  logic [28:0]       l_q;
  pgp_side_t         sd_out_q;
  logic [4:0]        k;
  logic [4:0]        sh;
  logic [61:0]       p;
  logic [31:0]       t;

  // Leading-one position of S and the shift that brings it to Q1.30.
  always_comb begin
    k = '0;
    for (int i = 0; i < 31; i++) begin
      if (side_i.s[i]) k = 5'(i);
    end
    sh = 5'd30 - k;
  end

  // One squaring per stage; the mantissa stays in [1, 2) as Q1.30.
  always_comb begin
    m_nx[0]  = '0;
    fr_nx[0] = '0;
    p = '0;
    t = '0;
    for (int i = 1; i < NS; i++) begin
      p = m_q[i-1] * m_q[i-1];
      t = p[61:30];
      if (t[31]) begin
        m_nx[i]  = t[31:1];
        fr_nx[i] = {fr_q[i-1][22:0], 1'b1};
      end else begin
        m_nx[i]  = t[30:0];
        fr_nx[i] = {fr_q[i-1][22:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) vld_q[i] <= 1'b0;
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int i = 1; i < NS; i++) vld_q[i] <= vld_q[i-1];
      vld_out_q <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]  <= side_i.s << sh;
      fr_q[0] <= '0;
      sh_q[0] <= sh;
      sd_q[0] <= side_i;
      for (int i = 1; i < NS; i++) begin
        m_q[i]  <= m_nx[i];
        fr_q[i] <= fr_nx[i];
        sh_q[i] <= sh_q[i-1];
        sd_q[i] <= sd_q[i-1];
      end
      l_q      <= {sh_q[NS-1], 24'd0} - {5'd0, fr_q[NS-1]};
      sd_out_q <= sd_q[NS-1];
    end
  end

  assign vld_o  = vld_out_q;
  assign l_o    = l_q;
  assign side_o = sd_out_q;

endmodule

// ----- rtl/core/pgp_isqrt.sv -----
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// Depends on pgp_pkg.
module pgp_isqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [63:0]        g_i,
  input  pgp_pkg::pgp_side_t side_i,
  output logic               vld_o,
  output logic [31:0]        f_o,
  output pgp_pkg::pgp_side_t side_o
);
  import pgp_pkg::*;

  localparam int unsigned NS = SQRT_STAGES;

  logic        vld_q  [NS];
  logic [63:0] v_q    [NS];
  logic [32:0] rem_q  [NS];
  logic [31:0] root_q [NS];
  pgp_side_t   sd_q   [NS];
  logic [63:0] v_in   [NS];
  logic [32:0] rem_in [NS];
  logic [31:0] rt_in  [NS];
  logic [32:0] rem_nx [NS];
  logic [31:0] rt_nx  [NS];
  logic [34:0] r;
  logic [34:0] trial;

  always_comb begin
    r = '0;
    trial = '0;
    for (int i = 0; i < NS; i++) begin
      if (i == 0) begin
        v_in[i]   = g_i;
        rem_in[i] = '0;
        rt_in[i]  = '0;
      end else begin
        v_in[i]   = v_q[i-1];
        rem_in[i] = rem_q[i-1];
        rt_in[i]  = root_q[i-1];
      end
      r     = {rem_in[i], v_in[i][63:62]};
      trial = {1'b0, rt_in[i], 2'b01};
      if (r >= trial) begin
        rem_nx[i] = 33'(r - trial);
        rt_nx[i]  = {rt_in[i][30:0], 1'b1};
      end else begin
        rem_nx[i] = r[32:0];
        rt_nx[i]  = {rt_in[i][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int i = 1; i < NS; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NS; i++) begin
        v_q[i]    <= {v_in[i][61:0], 2'b00};
        rem_q[i]  <= rem_nx[i];
        root_q[i] <= rt_nx[i];
        sd_q[i]   <= (i == 0) ? side_i : sd_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign f_o    = root_q[NS-1];
  assign side_o = sd_q[NS-1];

endmodule

// ----- rtl/core/polar_gaussian_pair_unit.sv -----
// Polar Gaussian pair unit: takes one beat of two 16-bit uniform codes per cycle and
// returns a beat of two saturated Q3.12 normal deviates, or nothing if the point falls
// outside the unit circle or on its center. The datapath is a 96-stage pipeline
// (log2 by 24 squarings, a 2-bit-per-stage divider, a 1-bit-per-stage square root).
// A result beat is presented from the output register once its input beat has passed
// through every stage in order. The whole pipeline stalls only while the output
// register holds a beat that the sink has not taken.
// Depends on pgp_pkg, pgp_log2, pgp_isqrt and polar_gaussian_pair_unit_macros.svh.
`include "polar_gaussian_pair_unit_macros.svh"

module polar_gaussian_pair_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [15:0] first_uniform, [31:16] second_uniform
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // [15:0] first_gaussian, [31:16] second_gaussian
);
  import pgp_pkg::*;

  logic        adv;
  logic        s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, out_vld_q;
  pgp_side_t   s1_sd_q, s2_sd_q, s3_sd_q, s4_sd_q, s5_sd_q;
  logic [30:0] sq0_q, sq1_q;
  logic [31:0] s_sum;
  logic [16:0] u0_ext, u1_ext;
  logic        lg_vld;
  logic [28:0] lg_l;
  pgp_side_t   lg_sd;
  logic [60:0] num_q;
  logic        dv_vld_q [DIV_STAGES];
  logic [63:0] dv_num_q [DIV_STAGES];
  logic [30:0] dv_rem_q [DIV_STAGES];
  logic [63:0] dv_quo_q [DIV_STAGES];
  pgp_side_t   dv_sd_q  [DIV_STAGES];
  logic [63:0] dn_in    [DIV_STAGES];
  logic [30:0] dr_in    [DIV_STAGES];
  logic [63:0] dq_in    [DIV_STAGES];
  logic [30:0] dr_nx    [DIV_STAGES];
  logic [63:0] dq_nx    [DIV_STAGES];
  logic [31:0] dt;
  logic [30:0] dr;
  logic        sq_vld;
  logic [31:0] sq_f;
  pgp_side_t   sq_sd;
  logic [48:0] p0_q, p1_q;
  logic [48:0] r0, r1;
  logic [15:0] g0, g1;
  logic [31:0] out_data_q;

  assign adv = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign u0_ext = {1'b0, s_axis_tdata_i[15:0]};
  assign u1_ext = {1'b0, s_axis_tdata_i[31:16]};
  assign s_sum  = {1'b0, sq0_q} + {1'b0, sq1_q};

  function automatic logic [30:0] dv_sd_in(input int i);
    return (i == 0) ? s4_sd_q.s : dv_sd_q[(i == 0) ? 0 : i-1].s;
  endfunction

  // Restoring division, two quotient bits per stage.
  always_comb begin
    dt = '0;
    dr = '0;
    for (int i = 0; i < DIV_STAGES; i++) begin
      if (i == 0) begin
        dn_in[i] = {num_q, 3'b000};
        dr_in[i] = '0;
        dq_in[i] = '0;
      end else begin
        dn_in[i] = dv_num_q[i-1];
        dr_in[i] = dv_rem_q[i-1];
        dq_in[i] = dv_quo_q[i-1];
      end
      dt = {dr_in[i], dn_in[i][63]};
      dr = (dt >= {1'b0, dv_sd_in(i)}) ? 31'(dt - {1'b0, dv_sd_in(i)}) : dt[30:0];
      dq_nx[i] = {dq_in[i][62:0], (dt >= {1'b0, dv_sd_in(i)})};
      dt = {dr, dn_in[i][62]};
      dr_nx[i] = (dt >= {1'b0, dv_sd_in(i)}) ? 31'(dt - {1'b0, dv_sd_in(i)}) : dt[30:0];
      dq_nx[i] = {dq_nx[i][62:0], (dt >= {1'b0, dv_sd_in(i)})};
    end
  end

  // Round half away from zero, then saturate to the signed 16-bit range.
  function automatic logic [15:0] pgp_scale(input logic neg, input logic [48:0] prod);
    logic [48:0] sum;
    logic [31:0] mag;
    sum = prod + 49'h1_0000;
    mag = sum[48:17];
    if (neg) begin
      if (mag > 32'd32768) mag = 32'd32768;
      return 16'(17'h1_0000 - {1'b0, mag[15:0]} - {mag[16], 16'd0});
    end
    if (mag > 32'd32767) mag = 32'd32767;
    return mag[15:0];
  endfunction

  assign r0 = p0_q;
  assign r1 = p1_q;
  assign g0 = pgp_scale(s5_sd_q.n0, r0);
  assign g1 = pgp_scale(s5_sd_q.n1, r1);

  pgp_log2 u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s3_vld_q),
    .side_i (s3_sd_q),
    .vld_o  (lg_vld),
    .l_o    (lg_l),
    .side_o (lg_sd)
  );

  pgp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (dv_vld_q[DIV_STAGES-1]),
    .g_i    (dv_quo_q[DIV_STAGES-1]),
    .side_i (dv_sd_q[DIV_STAGES-1]),
    .vld_o  (sq_vld),
    .f_o    (sq_f),
    .side_o (sq_sd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < DIV_STAGES; i++) dv_vld_q[i] <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= s_axis_tvalid_i;
      s2_vld_q <= s1_vld_q;
      // A point outside the circle or at its center leaves no result.
      s3_vld_q <= s2_vld_q && (s_sum != '0) && (s_sum <= {1'b0, ONE_SQ});
      s4_vld_q <= lg_vld;
      dv_vld_q[0] <= s4_vld_q;
      for (int i = 1; i < DIV_STAGES; i++) dv_vld_q[i] <= dv_vld_q[i-1];
      s5_vld_q  <= sq_vld;
      out_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sd_q    <= '{n0: !s_axis_tdata_i[15],
                      n1: !s_axis_tdata_i[31],
                      m0: s_axis_tdata_i[15] ? u0_ext - 17'd32768 : 17'd32768 - u0_ext,
                      m1: s_axis_tdata_i[31] ? u1_ext - 17'd32768 : 17'd32768 - u1_ext,
                      s:  '0};
      sq0_q      <= 31'(s1_sd_q.m0) * 31'(s1_sd_q.m0);
      sq1_q      <= 31'(s1_sd_q.m1) * 31'(s1_sd_q.m1);
      s2_sd_q    <= s1_sd_q;
      s3_sd_q    <= '{n0: s2_sd_q.n0, n1: s2_sd_q.n1, m0: s2_sd_q.m0, m1: s2_sd_q.m1,
                      s: s_sum[30:0]};
      num_q      <= LN2_Q32 * lg_l;
      s4_sd_q    <= lg_sd;
      for (int i = 0; i < DIV_STAGES; i++) begin
        dv_num_q[i] <= {dn_in[i][61:0], 2'b00};
        dv_rem_q[i] <= dr_nx[i];
        dv_quo_q[i] <= dq_nx[i];
        dv_sd_q[i]  <= (i == 0) ? s4_sd_q : dv_sd_q[(i == 0) ? 0 : i-1];
      end
      p0_q       <= sq_sd.m0 * sq_f;
      p1_q       <= sq_sd.m1 * sq_f;
      s5_sd_q    <= sq_sd;
      out_data_q <= {g1, g0};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  `PGP_ASSERT_IMP(a_s3_in_circle, s3_vld_q, (s3_sd_q.s != '0) && (s3_sd_q.s <= ONE_SQ))
  `PGP_ASSERT_NXT(a_stall_freezes, !adv, $stable(s4_vld_q) && $stable(s5_vld_q))
  `PGP_ASSERT_NXT(a_zero_mag_out, adv && s5_vld_q && (s5_sd_q.m0 == '0), m_axis_tdata_o[15:0] == '0)

endmodule
